// File: sv/tfpc_pkg.sv
// ----------------------------------------------------------------------------
// tfpc_pkg - shared definitions for the thermal frame PEC checker
// Frame geometry, CRC-8 constants, result kind codes, register map and the
// byte-wide CRC-8 update function.
// ----------------------------------------------------------------------------
package tfpc_pkg;

	// Frame geometry: one reference word, PIXEL_COUNT pixel words, then PEC.
	localparam int PIXEL_COUNT = 16;
	localparam int DATA_BYTES  = 2 * (PIXEL_COUNT + 1);
	localparam int COUNT_W     = 6;
	localparam int WORD_W      = COUNT_W - 1;
	localparam int INDEX_W     = 4;

	// CRC-8, polynomial x^8 + x^2 + x + 1, no reflection, no final xor.
	localparam logic [7:0] CRC_POLY   = 8'h07;
	localparam logic [7:0] CRC_TOP    = 8'h80;
	localparam logic [6:0] ADDR_RESET = 7'h0A;

	// Configuration port.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_DEVICE_ADDRESS = 1'b0;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_REFERENCE = 2'd0,
		KIND_PIXEL     = 2'd1,
		KIND_STATUS    = 2'd2
	} kind_t;

	// Eight shift-and-xor steps of the CRC register on one byte.
	function automatic logic [7:0] crc8_byte(input logic [7:0] v);
		logic [7:0] c;
		c = v;
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_TOP) != 8'h00) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	// CRC after folding in the read address byte of the sensor.
	function automatic logic [7:0] crc_seed(input logic [6:0] addr);
		return crc8_byte({addr, 1'b1});
	endfunction

endpackage

// File: sv/thermal_frame_pec_checker_core.sv
// ----------------------------------------------------------------------------
// thermal_frame_pec_checker_core - CRC-8 PEC check of thermal sensor frames
// Assembles little-endian temperature words from a byte stream, checks the
// frame's PEC byte against a CRC-8 seeded with the read address.
// ----------------------------------------------------------------------------
// Path: a byte lands in the input register when it is accepted, and its result
// word is then loaded into the result register, which drives the outputs.
// Throughput: one byte per cycle while the output is not stalled; the CRC-8
// byte update between the input register and the frame state is combinational
// and sets that rate.
// Reset: arst_n clears the pipeline valids and frame state; the block then
// ignores bytes until one arrives with frame_start set. device_address resets
// to 10.
module thermal_frame_pec_checker_core
	import tfpc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	// Configuration port.
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,

	// Byte input channel.
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	input  logic               frame_start,

	// Result channel.
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic [INDEX_W-1:0] pixel_index,
	output logic signed [15:0] temperature,
	output logic               pec_error,
	output logic               last
);

	// ------------------------------------------------------------------
	// Configuration register. Only byte addresses 0 to 3 (paddr[2] low) hold a
	// register; a write to addresses 4 to 7 is dropped and they read back as zero.
	// ------------------------------------------------------------------
	logic [6:0] device_address_q;
	logic       reg_write;

	assign pready    = 1'b1;
	assign reg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= ADDR_RESET;
		end else if (reg_write && (paddr[2] == REG_DEVICE_ADDRESS)) begin
			device_address_q <= pwdata[6:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_DEVICE_ADDRESS) begin
			prdata = {{(PDATA_W-7){1'b0}}, device_address_q};
		end
	end

	// ------------------------------------------------------------------
	// Flow control. The result register frees up when it is empty or its
	// word is being taken; the input register moves on at the same time.
	// The input register accepts a new byte whenever it is empty or moving,
	// so a byte can enter every cycle while the output is not stalled.
	// ------------------------------------------------------------------
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       out_valid_q;
	logic       advance;
	logic       in_take;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1  <= rx_byte;
			start_s1 <= frame_start;
		end
	end

	// ------------------------------------------------------------------
	// Frame state and the per-byte decision. A start byte restarts the
	// frame first, reseeding the CRC from the current address. Data bytes
	// are folded into the CRC; every odd byte completes a word. The byte
	// that follows the last data byte is the PEC and closes the frame.
	// ------------------------------------------------------------------
	logic [7:0]         running_crc_q;
	logic [COUNT_W-1:0] byte_count_q;
	logic [7:0]         low_byte_hold_q;
	logic               frame_done_q;

	logic [7:0]         crc_cur;
	logic [COUNT_W-1:0] count_cur;
	logic [7:0]         low_cur;
	logic               done_cur;

	logic [7:0]         crc_nxt;
	logic [COUNT_W-1:0] count_nxt;
	logic [7:0]         low_nxt;
	logic               done_nxt;

	logic               res_valid;
	kind_t              res_kind;
	logic [INDEX_W-1:0] res_index;
	logic [15:0]        res_temp;
	logic               res_err;
	logic               res_last;
	logic [WORD_W-1:0]  word_num;

	assign word_num = count_cur[COUNT_W-1:1];

	always_comb begin
		if (start_s1) begin
			crc_cur   = crc_seed(device_address_q);
			count_cur = '0;
			low_cur   = 8'h00;
			done_cur  = 1'b0;
		end else begin
			crc_cur   = running_crc_q;
			count_cur = byte_count_q;
			low_cur   = low_byte_hold_q;
			done_cur  = frame_done_q;
		end

		crc_nxt   = crc_cur;
		count_nxt = count_cur;
		low_nxt   = low_cur;
		done_nxt  = done_cur;

		res_valid = 1'b0;
		res_kind  = KIND_REFERENCE;
		res_index = '0;
		res_temp  = 16'h0000;
		res_err   = 1'b0;
		res_last  = 1'b0;

		if (!done_cur) begin
			if (count_cur < COUNT_W'(DATA_BYTES)) begin
				crc_nxt   = crc8_byte(byte_s1 ^ crc_cur);
				count_nxt = count_cur + COUNT_W'(1);
				if (!count_cur[0]) begin
					low_nxt = byte_s1;
				end else begin
					res_valid = 1'b1;
					res_temp  = {byte_s1, low_cur};
					if (word_num == '0) begin
						res_kind = KIND_REFERENCE;
					end else begin
						res_kind  = KIND_PIXEL;
						res_index = INDEX_W'(word_num - WORD_W'(1));
					end
				end
			end else begin
				// PEC byte: compare, report and wait for the next start.
				res_valid = 1'b1;
				res_kind  = KIND_STATUS;
				res_err   = (crc_cur != byte_s1);
				res_last  = 1'b1;
				done_nxt  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q   <= crc_seed(ADDR_RESET);
			byte_count_q    <= '0;
			low_byte_hold_q <= 8'h00;
			frame_done_q    <= 1'b1;
		end else if (valid_s1 && advance) begin
			running_crc_q   <= crc_nxt;
			byte_count_q    <= count_nxt;
			low_byte_hold_q <= low_nxt;
			frame_done_q    <= done_nxt;
		end
	end

	// ------------------------------------------------------------------
	// Result register. It loads whenever it frees up; bytes that give no
	// result leave it empty.
	// ------------------------------------------------------------------
	logic [1:0]         kind_q;
	logic [INDEX_W-1:0] pixel_index_q;
	logic [15:0]        temperature_q;
	logic               pec_error_q;
	logic               last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			kind_q        <= res_kind;
			pixel_index_q <= res_index;
			temperature_q <= res_temp;
			pec_error_q   <= res_err;
			last_q        <= res_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign pixel_index = pixel_index_q;
	assign temperature = signed'(temperature_q);
	assign pec_error   = pec_error_q;
	assign last        = last_q;

endmodule
